>>> hdl/ntp_pkg.sv
// ----------------------------------------------------------------------------
// ntp_pkg : note to pitch converter package
// Widths, pitch limits and the two exponential tables.
// ----------------------------------------------------------------------------
package ntp_pkg;

   localparam int NOTE_W  = 16;
   localparam int PITCH_W = 14;
   localparam int FRAC_W  = 7;
   localparam int IDX_W   = 4;
   localparam int QUO_W   = 13;
   localparam int SH_W    = 5;

   localparam logic [PITCH_W-1:0] PITCH_MAX = 14'h3FFF;

   // d + 32772 (multiple of 12), reciprocal ceil(2^19 / 12)
   localparam logic [16:0] DIV_BIAS  = 17'd32772;
   localparam logic [15:0] DIV_RECIP = 16'd43691;
   localparam int          DIV_SHIFT = 19;

   // quotient thresholds: octave >= 2 and octave <= -15
   localparam logic [QUO_W-1:0] QUO_SAT  = 13'd2733;
   localparam logic [QUO_W-1:0] QUO_ZERO = 13'd2716;
   localparam logic [IDX_W-1:0] OCT_STEPS = 4'd12;

   localparam logic [15:0] FRAC_TAB [128] = '{
      16'h8000, 16'h800e, 16'h801d, 16'h802c, 16'h803b, 16'h804a, 16'h8058, 16'h8067,
      16'h8076, 16'h8085, 16'h8094, 16'h80a3, 16'h80b1, 16'h80c0, 16'h80cf, 16'h80de,
      16'h80ed, 16'h80fc, 16'h810b, 16'h811a, 16'h8129, 16'h8138, 16'h8146, 16'h8155,
      16'h8164, 16'h8173, 16'h8182, 16'h8191, 16'h81a0, 16'h81af, 16'h81be, 16'h81cd,
      16'h81dc, 16'h81eb, 16'h81fa, 16'h8209, 16'h8218, 16'h8227, 16'h8236, 16'h8245,
      16'h8254, 16'h8263, 16'h8272, 16'h8282, 16'h8291, 16'h82a0, 16'h82af, 16'h82be,
      16'h82cd, 16'h82dc, 16'h82eb, 16'h82fa, 16'h830a, 16'h8319, 16'h8328, 16'h8337,
      16'h8346, 16'h8355, 16'h8364, 16'h8374, 16'h8383, 16'h8392, 16'h83a1, 16'h83b0,
      16'h83c0, 16'h83cf, 16'h83de, 16'h83ed, 16'h83fd, 16'h840c, 16'h841b, 16'h842a,
      16'h843a, 16'h8449, 16'h8458, 16'h8468, 16'h8477, 16'h8486, 16'h8495, 16'h84a5,
      16'h84b4, 16'h84c3, 16'h84d3, 16'h84e2, 16'h84f1, 16'h8501, 16'h8510, 16'h8520,
      16'h852f, 16'h853e, 16'h854e, 16'h855d, 16'h856d, 16'h857c, 16'h858b, 16'h859b,
      16'h85aa, 16'h85ba, 16'h85c9, 16'h85d9, 16'h85e8, 16'h85f8, 16'h8607, 16'h8617,
      16'h8626, 16'h8636, 16'h8645, 16'h8655, 16'h8664, 16'h8674, 16'h8683, 16'h8693,
      16'h86a2, 16'h86b2, 16'h86c1, 16'h86d1, 16'h86e0, 16'h86f0, 16'h8700, 16'h870f,
      16'h871f, 16'h872e, 16'h873e, 16'h874e, 16'h875d, 16'h876d, 16'h877d, 16'h878c
   };

   function automatic logic [15:0] semi_lookup(input logic [IDX_W-1:0] idx);
      logic [15:0] val;
      case (idx)
         4'd0:    val = 16'h8000;
         4'd1:    val = 16'h879c;
         4'd2:    val = 16'h8fac;
         4'd3:    val = 16'h9837;
         4'd4:    val = 16'ha145;
         4'd5:    val = 16'haadc;
         4'd6:    val = 16'hb504;
         4'd7:    val = 16'hbfc8;
         4'd8:    val = 16'hcb2f;
         4'd9:    val = 16'hd744;
         4'd10:   val = 16'he411;
         4'd11:   val = 16'hf1a1;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

endpackage

>>> hdl/note_to_pitch_converter_unit.sv
// ----------------------------------------------------------------------------
// note_to_pitch_converter_unit : note to sample pitch
// Five stage pipeline: fine sum and note difference, divide by 12 by
// reciprocal multiply, table lookup, table product, rounded octave shift.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while rsp_stall is low; every stage is a
// single register that takes a new word each cycle unless it is held.
// Stalls collapse bubbles; a stage holds only when the next one is full.
// Reset clears the stage valid bits; payload registers are not reset.
module note_to_pitch_converter_unit
   import ntp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [NOTE_W-1:0]  req_note_number,
   input  logic signed [NOTE_W-1:0]  req_fine_tune,
   input  logic        [7:0]         req_center_note,
   input  logic        [7:0]         req_tone_shift,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [PITCH_W-1:0] rsp_pitch
);

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: fine sum, split, note difference
   logic [15:0]        sum1;
   logic [15:0]        d_in;
   logic [15:0]        d_ff;
   logic [FRAC_W-1:0]  frac1_ff;

   always_comb begin
      sum1 = {8'd0, req_tone_shift} + req_fine_tune;
      d_in = req_note_number + {{7{sum1[15]}}, sum1[15:7]} - {8'd0, req_center_note};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d_ff     <= d_in;
         frac1_ff <= sum1[FRAC_W-1:0];
      end
   end

   // stage 2: biased difference times reciprocal of 12
   logic [16:0]        ud2;
   logic [32:0]        prod2;
   logic [QUO_W-1:0]   quo_ff;
   logic [IDX_W-1:0]   udlo_ff;
   logic [FRAC_W-1:0]  frac2_ff;

   always_comb begin
      ud2   = {d_ff[15], d_ff} + DIV_BIAS;
      prod2 = ud2 * {17'd0, DIV_RECIP};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         quo_ff   <= prod2[DIV_SHIFT +: QUO_W];
         udlo_ff  <= ud2[IDX_W-1:0];
         frac2_ff <= frac1_ff;
      end
   end

   // stage 3: remainder, octave class, table lookups
   logic [IDX_W-1:0]   idx3;
   logic [15:0]        semi_ff, fine_ff;
   logic               sat3_ff, zero3_ff;
   logic [SH_W-1:0]    sh3_ff;

   assign idx3 = udlo_ff - ({quo_ff[1:0], 2'b00} + {quo_ff[0], 3'b000});

   always_ff @(posedge clock) begin
      if (en3) begin
         semi_ff  <= semi_lookup(idx3);
         fine_ff  <= FRAC_TAB[frac2_ff];
         sat3_ff  <= quo_ff >= QUO_SAT;
         zero3_ff <= quo_ff <= QUO_ZERO;
         sh3_ff   <= SH_W'(QUO_SAT - quo_ff);
      end
   end

   // stage 4: table product
   logic [31:0]        prod4;
   logic [15:0]        p_ff;
   logic               sat4_ff, zero4_ff;
   logic [SH_W-1:0]    sh4_ff;

   assign prod4 = semi_ff * fine_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         p_ff     <= prod4[31:16];
         sat4_ff  <= sat3_ff;
         zero4_ff <= zero3_ff;
         sh4_ff   <= sh3_ff;
      end
   end

   // stage 5: rounded shift and clamp
   logic [16:0]        rnd5;
   logic [16:0]        shr5;
   logic [PITCH_W-1:0] pitch_in;
   logic [PITCH_W-1:0] pitch_ff;

   always_comb begin
      rnd5 = {1'b0, p_ff} + (17'd1 << (sh4_ff - 5'd1));
      shr5 = rnd5 >> sh4_ff;
      if (sat4_ff) begin
         pitch_in = PITCH_MAX;
      end else if (zero4_ff) begin
         pitch_in = '0;
      end else begin
         pitch_in = shr5[PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_pitch = pitch_ff;

   // checks
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> idx3 < OCT_STEPS)
      else $error("semitone index out of range");

   a_class_exclusive: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> !(sat3_ff && zero3_ff))
      else $error("saturate and zero both set");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !sat4_ff && !zero4_ff) |-> (sh4_ff != 5'd0 && sh4_ff <= 5'd16))
      else $error("octave shift out of range");

endmodule

>>> sim/note_to_pitch_converter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_to_pitch_converter_unit_test : self-checking bench for the note to
// pitch converter
// Drives request words with random gaps against random response stalls.
// Each accepted request is run through an independent pitch predictor, and
// each response word is checked in order against the oldest prediction.
// A directed set hits saturation, the deep shift to zero and both 16-bit
// wraps. Random words follow, mostly near the center note, some fully random.
// ----------------------------------------------------------------------------
module note_to_pitch_converter_unit_test;
   import ntp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int WORDS_PER_BLOCK = 250;

   localparam logic [15:0] SEMITONE_RATIO [12] = '{
      16'h8000, 16'h879c, 16'h8fac, 16'h9837, 16'h a145, 16'haadc,
      16'hb504, 16'hbfc8, 16'hcb2f, 16'hd744, 16'he411, 16'hf1a1
   };

   class pitch_scoreboard;
      logic [PITCH_W-1:0] pending_pitch [$];
      int                 pending_seq [$];
      int                 words_in;
      int                 words_out;
      int                 saturated;
      int                 flushed;
      int                 errors;

      function logic [PITCH_W-1:0] predict_pitch(logic signed [NOTE_W-1:0] note,
                                                 logic signed [NOTE_W-1:0] fine,
                                                 logic [7:0] center,
                                                 logic [7:0] shift);
         logic signed [15:0] fine_sum;
         logic signed [15:0] semis;
         logic signed [15:0] diff;
         logic [6:0]         frac;
         int                 d;
         int                 octave;
         int                 step;
         int                 rshift;
         logic [31:0]        prod;
         logic [31:0]        rounded;
         fine_sum = fine + $signed({8'd0, shift});
         semis    = fine_sum >>> 7;
         frac     = fine_sum[6:0];
         diff     = note + semis - $signed({8'd0, center});
         d        = diff;
         octave   = (d >= 0) ? d / 12 : -((11 - d) / 12);
         step     = d - 12 * octave;
         if (octave >= 2) return PITCH_MAX;
         rshift = 2 - octave;
         if (rshift >= 17) return '0;
         prod    = SEMITONE_RATIO[step] * FRAC_TAB[frac];
         rounded = ((prod >> 16) + (32'd1 << (rshift - 1))) >> rshift;
         return rounded[PITCH_W-1:0];
      endfunction

      function int outstanding();
         return pending_pitch.size();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task note_request(logic signed [NOTE_W-1:0] note, logic signed [NOTE_W-1:0] fine,
                        logic [7:0] center, logic [7:0] shift);
         logic [PITCH_W-1:0] pitch;
         pitch = predict_pitch(note, fine, center, shift);
         if (pitch == PITCH_MAX) saturated++;
         if (pitch == '0) flushed++;
         pending_pitch.push_back(pitch);
         pending_seq.push_back(words_in);
         words_in++;
      endtask

      task check_response(logic [PITCH_W-1:0] got);
         logic [PITCH_W-1:0] want;
         int                 seq;
         if (pending_pitch.size() == 0) begin
            report($sformatf("response word %04h with nothing pending", got));
            return;
         end
         want = pending_pitch.pop_front();
         seq  = pending_seq.pop_front();
         words_out++;
         if (got !== want)
            report($sformatf("word %0d pitch got %04h want %04h", seq, got, want));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [NOTE_W-1:0]  req_note_number;
   logic signed [NOTE_W-1:0]  req_fine_tune;
   logic        [7:0]         req_center_note;
   logic        [7:0]         req_tone_shift;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic        [PITCH_W-1:0] rsp_pitch;

   bit              calm;
   pitch_scoreboard pitch_sb = new;

   note_to_pitch_converter_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_note_number (req_note_number),
      .req_fine_tune   (req_fine_tune),
      .req_center_note (req_center_note),
      .req_tone_shift  (req_tone_shift),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pitch       (rsp_pitch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input int note, input int fine, input int center,
                            input int shift);
      int gap;
      req_valid       <= 1'b1;
      req_note_number <= 16'(note);
      req_fine_tune   <= 16'(fine);
      req_center_note <= 8'(center);
      req_tone_shift  <= 8'(shift);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pitch_sb.note_request(req_note_number, req_fine_tune, req_center_note,
                               req_tone_shift);
      if (!reset && rsp_valid && !rsp_stall)
         pitch_sb.check_response(rsp_pitch);
   end

   initial begin : response_backpressure
      int n;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int blk;
      int i;
      int center;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_note_number <= '0;
      req_fine_tune   <= '0;
      req_center_note <= '0;
      req_tone_shift  <= '0;
      calm = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // base rate, saturation edge, deep shift edge
      send_word(60, 0, 60, 0);
      send_word(84, 0, 60, 0);
      send_word(83, 127, 60, 0);
      send_word(83, 128, 60, 0);
      send_word(-120, 0, 60, 0);
      send_word(-109, 0, 60, 0);
      send_word(-108, 0, 60, 0);
      // note and fine extremes, both wraps
      send_word(32767, 0, 0, 0);
      send_word(-32768, 0, 0, 0);
      send_word(-32768, 0, 255, 0);
      send_word(0, 32767, 0, 255);
      send_word(0, -32768, 0, 0);
      send_word(0, -32768, 0, 255);
      send_word(-32768, -32768, 255, 255);
      send_word(32767, 32767, 255, 255);
      // floor division around zero
      send_word(0, -1, 0, 0);
      send_word(0, -1, 0, 1);
      send_word(0, 0, 255, 255);
      send_word(255, 0, 255, 255);
      send_word(-1, 0, 0, 0);
      send_word(11, 0, 0, 0);
      send_word(12, 0, 0, 0);
      send_word(-12, 0, 0, 0);
      send_word(-13, 0, 0, 0);
      send_word(23, 127, 0, 0);

      for (blk = 0; blk < 3; blk++) begin
         calm = (blk == 1);
         for (i = 0; i < WORDS_PER_BLOCK; i++) begin
            center = $urandom_range(0, 255);
            if ($urandom_range(0, 9) < 7)
               send_word(center + $urandom_range(0, 232) - 200,
                         $urandom_range(0, 1024) - 512, center, $urandom_range(0, 255));
            else
               send_word($urandom, $urandom, center, $urandom_range(0, 255));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pitch_sb.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request words and %0d response words under gaps and stalls",
               pitch_sb.words_in, pitch_sb.words_out);
      $display("%0d saturated, %0d shifted to zero, %0d mismatches",
               pitch_sb.saturated, pitch_sb.flushed, pitch_sb.errors);
      if (pitch_sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/ntp_pkg.sv
hdl/note_to_pitch_converter_unit.sv
sim/note_to_pitch_converter_unit_test.sv
